[hw/rtl/lmf_pkg.sv]
// Shared types and constants for the line message framer.
package lmf_pkg;

    // Operation carried in tuser
    typedef enum logic [1:0] {
        FN_RECV    = 2'd0,
        FN_RELEASE = 2'd1,
        FN_READ    = 2'd2,
        FN_SPARE   = 2'd3
    } t_func;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUERY = 8'h3F;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    // Result word, first member in the highest bits (accepted lands in bit 0)
    typedef struct packed {
        logic [7:0] read_byte;
        logic       has_query;
        logic [5:0] line_length;
        logic       overflow;
        logic       line_ready;
        logic       accepted;
    } t_result;

endpackage

[hw/rtl/lmf_out_queue.sv]
// Small result queue that decouples the update stage from the output stream.
module lmf_out_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  lmf_pkg::t_result           i_data,
    input  logic                       i_ready,
    output logic                       o_valid,
    output lmf_pkg::t_result           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lmf_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= CW'(r_cnt + 1'b1);
                2'b01:   r_cnt <= CW'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hw/rtl/line_message_framer.sv]
// Line message framer: collects newline-terminated lines, one buffer per interface.
// One word a cycle is taken and answered, back to back; the result of a word passes the
// update stage registers and then the result queue before it is valid on m_axis.
// The rate is set by the single read-modify-
// write of the per-interface state memory (ready, query, length), read in the accept
// cycle and written the cycle after, with one-word forwarding for the same interface and
// for the line store. Reset needs no clearing pass: per-interface valid bits make state
// read as zero until written. A four-entry result queue keeps input flowing while
// m_axis is stalled; s_axis_tready drops only when that queue would fill.
module line_message_framer #(
    parameter int unsigned NUM_IFACES = 4,
    parameter int unsigned BUF_SIZE   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // iface[1:0], data_byte[9:2], read_index[15:10]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // accepted, line_ready, overflow, line_length[8:3],
                                        // has_query, read_byte[17:10], zero pad
);

    localparam int unsigned IF_W     = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int unsigned LEN_W    = $clog2(BUF_SIZE);
    localparam int unsigned AW       = IF_W + LEN_W;
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             rdy;
        logic             qry;
        logic [LEN_W-1:0] len;
    } t_line_st;

    // ---------------- input decode ----------------
    logic [IF_W+1:0]  if_ext;
    logic [IF_W-1:0]  if_idx;
    logic             if_ok;
    logic [LEN_W+5:0] idx_ext;
    logic [LEN_W-1:0] idx_pos;
    logic             idx_ok;
    logic             in_acc;

    assign if_ext  = {{IF_W{1'b0}}, s_axis_tdata[1:0]};
    assign if_idx  = if_ext[IF_W-1:0];
    assign if_ok   = (if_ext < (IF_W + 2)'(NUM_IFACES));
    assign idx_ext = {{LEN_W{1'b0}}, s_axis_tdata[15:10]};
    assign idx_pos = idx_ext[LEN_W-1:0];
    assign idx_ok  = (idx_ext < (LEN_W + 6)'(BUF_SIZE));
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // ---------------- memories ----------------
    t_line_st   st_mem [1 << IF_W];
    logic [7:0] ls_mem [1 << AW];
    logic [(1 << IF_W)-1:0] r_st_vld;

    // ---------------- update stage registers ----------------
    logic             r_s1_vld;
    lmf_pkg::t_func   r_s1_func;
    logic [IF_W-1:0]  r_s1_if;
    logic             r_s1_if_ok;
    logic [7:0]       r_s1_byte;
    logic             r_s1_idx_ok;
    t_line_st         r_st_rd;
    logic             r_st_rd_v;
    logic             r_fwd_hit;
    t_line_st         r_fwd_st;
    logic [7:0]       r_ls_rd;
    logic             r_ls_fwd_hit;
    logic [7:0]       r_ls_fwd_byte;

    t_line_st         st_cur;
    t_line_st         st_next;
    logic             ls_wr;
    logic [AW-1:0]    ls_wr_addr;
    logic [7:0]       rd_byte;
    logic [LEN_W+5:0] len_ext;
    lmf_pkg::t_result res;
    logic [OQ_CW-1:0] oq_level;
    lmf_pkg::t_result oq_data;

    assign st_cur = r_fwd_hit ? r_fwd_st : (r_st_rd_v ? r_st_rd : '0);
    assign rd_byte = r_ls_fwd_hit ? r_ls_fwd_byte : r_ls_rd;
    assign ls_wr_addr = {r_s1_if, st_cur.len};

    always_comb begin
        st_next = st_cur;
        ls_wr   = 1'b0;
        res     = '0;
        case (r_s1_func)
            lmf_pkg::FN_RECV: begin
                if (!st_cur.rdy) begin
                    res.accepted = 1'b1;
                    if (st_cur.len >= LEN_W'(BUF_SIZE - 1)) begin
                        st_next.len  = '0;
                        st_next.qry  = 1'b0;
                        res.overflow = 1'b1;
                    end else if (r_s1_byte != lmf_pkg::CH_CR) begin
                        ls_wr       = 1'b1;
                        st_next.len = LEN_W'(st_cur.len + 1'b1);
                        if (r_s1_byte == lmf_pkg::CH_QUERY) begin
                            st_next.qry = 1'b1;
                        end
                        // newline completes a line unless it is the first byte
                        if (r_s1_byte == lmf_pkg::CH_LF && st_cur.len != '0) begin
                            st_next.rdy = 1'b1;
                        end
                    end
                end
            end
            lmf_pkg::FN_RELEASE: begin
                if (st_cur.rdy) begin
                    st_next = '0;
                end
            end
            lmf_pkg::FN_READ: begin
                res.read_byte = r_s1_idx_ok ? rd_byte : 8'd0;
            end
            default: begin
                st_next = st_cur;
            end
        endcase
        len_ext         = {6'd0, st_next.len};
        res.line_ready  = st_next.rdy;
        res.line_length = len_ext[5:0];
        res.has_query   = st_next.rdy && st_next.qry;
        if (!r_s1_if_ok) begin
            res   = '0;
            ls_wr = 1'b0;
        end
    end

    // memory ports: read at accept, write back from the update stage
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && r_s1_if_ok) begin
            st_mem[r_s1_if] <= st_next;
        end
        if (in_acc) begin
            r_st_rd <= st_mem[if_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && ls_wr) begin
            ls_mem[ls_wr_addr] <= r_s1_byte;
        end
        if (in_acc) begin
            r_ls_rd <= ls_mem[{if_idx, idx_pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func     <= lmf_pkg::t_func'(s_axis_tuser);
            r_s1_if       <= if_idx;
            r_s1_if_ok    <= if_ok;
            r_s1_byte     <= s_axis_tdata[9:2];
            r_s1_idx_ok   <= idx_ok;
            r_st_rd_v     <= r_st_vld[if_idx];
            r_fwd_st      <= st_next;
            r_ls_fwd_byte <= r_s1_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_st_vld     <= '0;
            r_fwd_hit    <= 1'b0;
            r_ls_fwd_hit <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
            if (r_s1_vld && r_s1_if_ok) begin
                r_st_vld[r_s1_if] <= 1'b1;
            end
            if (in_acc) begin
                // the write landing this edge is not yet visible to the read
                r_fwd_hit    <= r_s1_vld && r_s1_if_ok && (r_s1_if == if_idx);
                r_ls_fwd_hit <= r_s1_vld && ls_wr && (ls_wr_addr == {if_idx, idx_pos});
            end
        end
    end

    // ---------------- result queue ----------------
    lmf_out_queue #(
        .DEPTH (OQ_DEPTH)
    ) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_data  (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (oq_data),
        .o_level (oq_level)
    );

    // room for the word in the update stage plus the one accepted now
    assign s_axis_tready = (({1'b0, oq_level} + (OQ_CW + 1)'(r_s1_vld))
                            < (OQ_CW + 1)'(OQ_DEPTH));
    assign m_axis_tdata  = {6'd0, oq_data};

    // ---------------- assertions ----------------
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (oq_level < OQ_CW'(OQ_DEPTH)))
        else $error("result pushed into full queue");

    a_ovf_is_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && res.overflow) |-> res.accepted)
        else $error("overflow without accepting the byte");

    a_ready_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_if_ok && st_next.rdy && !st_cur.rdy) |-> (st_next.len > LEN_W'(1)))
        else $error("line marked ready with length of one or less");

    a_bad_if: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !r_s1_if_ok) |-> (res == '0 && !ls_wr))
        else $error("out of range interface changed state or result");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_fwd_hit) |-> $past(r_s1_vld))
        else $error("forward hit without a preceding update");

endmodule

[sim/line_frame_monitor.sv]
// Monitor for the line message framer: predicts each result word and compares it.
`timescale 1ns / 100ps

module line_frame_monitor #(
    parameter int unsigned NUM_IFACES = 4,
    parameter int unsigned BUF_SIZE   = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    input  logic [15:0]                      i_s_axis_tdata,  // iface, data_byte, read_index
    input  logic [1:0]                       i_s_axis_tuser,  // func
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [23:0]                      i_m_axis_tdata,  // t_result, zero pad
    output int                               o_fail_count,
    output int                               o_pending,
    output logic [NUM_IFACES*BUF_SIZE-1:0]   o_stored_mask
);

    // per-interface line state
    logic       line_rdy [NUM_IFACES];
    logic       line_qry [NUM_IFACES];
    int         line_len [NUM_IFACES];
    logic [7:0] line_bytes [NUM_IFACES][BUF_SIZE];
    logic [NUM_IFACES*BUF_SIZE-1:0] written_map;

    lmf_pkg::t_result status_queue[$];
    int               mismatches;

    function automatic lmf_pkg::t_result advance_line(lmf_pkg::t_func f, logic [1:0] ifc,
                                                      logic [7:0] b, logic [5:0] idx);
        lmf_pkg::t_result r;
        int               n;
        r = '0;
        if (ifc >= NUM_IFACES)
            return r;
        n = line_len[ifc];
        case (f)
            lmf_pkg::FN_RECV: begin
                if (!line_rdy[ifc]) begin
                    r.accepted = 1'b1;
                    if (n >= BUF_SIZE - 1) begin
                        // full buffer: byte dropped, line thrown away
                        line_len[ifc] = 0;
                        line_qry[ifc] = 1'b0;
                        r.overflow    = 1'b1;
                    end else if (b != lmf_pkg::CH_CR) begin
                        line_bytes[ifc][n] = b;
                        written_map[ifc*BUF_SIZE+n] = 1'b1;
                        line_len[ifc] = n + 1;
                        if (b == lmf_pkg::CH_QUERY)
                            line_qry[ifc] = 1'b1;
                        if (b == lmf_pkg::CH_LF && n + 1 > 1)
                            line_rdy[ifc] = 1'b1;
                    end
                end
            end
            lmf_pkg::FN_RELEASE: begin
                if (line_rdy[ifc]) begin
                    line_rdy[ifc] = 1'b0;
                    line_len[ifc] = 0;
                    line_qry[ifc] = 1'b0;
                end
            end
            lmf_pkg::FN_READ: begin
                if (idx < BUF_SIZE)
                    r.read_byte = line_bytes[ifc][idx];
            end
            default: ;
        endcase
        r.line_ready  = line_rdy[ifc];
        r.line_length = line_len[ifc][5:0];
        r.has_query   = line_rdy[ifc] & line_qry[ifc];
        return r;
    endfunction

    function automatic int field_differs(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        lmf_pkg::t_result want;
        lmf_pkg::t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IFACES; i++) begin
                line_rdy[i] = 1'b0;
                line_qry[i] = 1'b0;
                line_len[i] = 0;
            end
            written_map = '0;
            status_queue.delete();
            mismatches = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                status_queue.push_back(advance_line(lmf_pkg::t_func'(i_s_axis_tuser),
                                                    i_s_axis_tdata[1:0],
                                                    i_s_axis_tdata[9:2],
                                                    i_s_axis_tdata[15:10]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = lmf_pkg::t_result'(i_m_axis_tdata[17:0]);
                if (status_queue.size() == 0) begin
                    $error("result word with no status expected: %h", i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = status_queue.pop_front();
                    mismatches += field_differs("accepted", want.accepted, got.accepted);
                    mismatches += field_differs("line_ready", want.line_ready, got.line_ready);
                    mismatches += field_differs("overflow", want.overflow, got.overflow);
                    mismatches += field_differs("line_length", want.line_length,
                                                got.line_length);
                    mismatches += field_differs("has_query", want.has_query, got.has_query);
                    mismatches += field_differs("read_byte", want.read_byte, got.read_byte);
                end
                mismatches += field_differs("pad", 0, i_m_axis_tdata[23:18]);
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= status_queue.size();
        o_stored_mask <= written_map;
    end

endmodule

[sim/line_message_framer_test.sv]
// Top of the line message framer testbench: stimulus, result sink and verdict.
`timescale 1ns / 100ps

module line_message_framer_test;

    localparam int N_IF         = 4;
    localparam int BUF          = 64;
    localparam int RANDOM_WORDS = 1700;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // iface[1:0], data_byte[9:2], read_index[15:10]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // accepted, line_ready, overflow, line_length, has_query,
                                 // read_byte, zero pad

    int              fail_count;
    int              pending;
    logic [N_IF*BUF-1:0] stored_mask;
    bit              calm;
    int              words_sent;

    line_message_framer #(.NUM_IFACES(N_IF), .BUF_SIZE(BUF)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    line_frame_monitor #(.NUM_IFACES(N_IF), .BUF_SIZE(BUF)) monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_stored_mask   (stored_mask)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result sink: random stalls, two long hold-offs to back up the result queue
    initial begin
        int cyc;
        int hold_left;
        cyc = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else begin
                cyc++;
                if (cyc == 400 || cyc == 2500)
                    hold_left = 80;
                if (hold_left > 0) begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
                end
            end
        end
    end

    // Reads are steered to entries already written; the mask lags by a word or two,
    // which only makes it more cautious.
    task automatic put_word(lmf_pkg::t_func f, logic [1:0] ifc, logic [7:0] b,
                            logic [5:0] idx);
        bit found;
        if (f == lmf_pkg::FN_READ && !stored_mask[ifc*BUF+idx]) begin
            found = 1'b0;
            for (int k = 0; k < 8 && !found; k++) begin
                idx   = $urandom_range(0, BUF - 2);
                found = stored_mask[ifc*BUF+idx];
            end
            if (!found)
                f = lmf_pkg::FN_SPARE;
        end
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, b, ifc};
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    function automatic logic [7:0] line_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return lmf_pkg::CH_CR;
        if (r < 18)
            return lmf_pkg::CH_QUERY;
        if (r < 22)
            return lmf_pkg::CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] any_index();
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin
        int          kind;
        int          n;
        logic [1:0]  ifc;
        logic [7:0]  b;
        words_sent = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= lmf_pkg::FN_RECV;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone newline, CR skip, query line, refusal, reads, releases
        put_word(lmf_pkg::FN_RECV, 2'd0, lmf_pkg::CH_LF, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd0, 8'h41, 6'd63);
        put_word(lmf_pkg::FN_RECV, 2'd0, lmf_pkg::CH_QUERY, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd0, lmf_pkg::CH_CR, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd0, lmf_pkg::CH_LF, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd0, 8'h5A, 6'd0);
        put_word(lmf_pkg::FN_READ, 2'd0, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_READ, 2'd0, 8'hFF, 6'd2);
        put_word(lmf_pkg::FN_SPARE, 2'd0, 8'hFF, 6'd63);
        put_word(lmf_pkg::FN_RELEASE, 2'd0, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_RELEASE, 2'd0, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd3, 8'hFF, 6'd63);
        put_word(lmf_pkg::FN_RECV, 2'd3, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd3, lmf_pkg::CH_LF, 6'd0);
        put_word(lmf_pkg::FN_RELEASE, 2'd2, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_READ, 2'd3, 8'h00, 6'd1);
        put_word(lmf_pkg::FN_RECV, 2'd3, 8'h80, 6'd0);
        put_word(lmf_pkg::FN_RELEASE, 2'd3, 8'hFF, 6'd63);
        put_word(lmf_pkg::FN_RECV, 2'd1, lmf_pkg::CH_CR, 6'd21);
        put_word(lmf_pkg::FN_SPARE, 2'd1, 8'h00, 6'd0);
        put_word(lmf_pkg::FN_RECV, 2'd2, lmf_pkg::CH_QUERY, 6'd42);

        while (words_sent < RANDOM_WORDS + 21) begin
            calm = (words_sent >= 800 && words_sent < 1100);
            kind = $urandom_range(0, 99);
            ifc  = 2'($urandom_range(0, N_IF - 1));
            if (kind < 60) begin
                // ordinary line with occasional traffic on any interface
                put_word(lmf_pkg::FN_RELEASE, ifc, 8'($urandom_range(0, 255)), any_index());
                n = $urandom_range(1, 12);
                repeat (n) begin
                    put_word(lmf_pkg::FN_RECV, ifc, line_char(), any_index());
                    if ($urandom_range(0, 99) < 15)
                        put_word(lmf_pkg::t_func'($urandom_range(0, 3)),
                                 2'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)), any_index());
                end
                put_word(lmf_pkg::FN_RECV, ifc, lmf_pkg::CH_LF, any_index());
                repeat ($urandom_range(0, 3))
                    put_word(lmf_pkg::FN_READ, ifc, 8'($urandom_range(0, 255)), any_index());
                if ($urandom_range(0, 99) < 70)
                    put_word(lmf_pkg::FN_RELEASE, ifc, 8'($urandom_range(0, 255)),
                             any_index());
            end else if (kind < 70) begin
                // fill past the end of the buffer, the byte past the end sometimes a CR, then up to two more
                put_word(lmf_pkg::FN_RELEASE, ifc, 8'h00, any_index());
                repeat (BUF - 1)
                    put_word(lmf_pkg::FN_RECV, ifc, 8'($urandom_range(32, 255)), any_index());
                b = ($urandom_range(0, 1) != 0) ? lmf_pkg::CH_CR : 8'($urandom_range(0, 255));
                put_word(lmf_pkg::FN_RECV, ifc, b, any_index());
                repeat ($urandom_range(0, 2))
                    put_word(lmf_pkg::FN_RECV, ifc, line_char(), any_index());
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4))
                    put_word(lmf_pkg::FN_READ, 2'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)), any_index());
            end else begin
                repeat ($urandom_range(1, 4))
                    put_word(lmf_pkg::t_func'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)), any_index());
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        for (int k = 0; k < 20000 && pending != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
